// ----- hw/rtl/fpc_pkg.sv -----
// shared constants for the plasma e-field cell update
package fpc_pkg;

    // default number formats
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIELD_BITS_DEF = 32;

    // headroom of the internal accumulator over the field width
    localparam int ACC_GUARD = 8;

    // coefficient widths
    localparam int ASPECT_W = 18;
    localparam int DECAY_W  = 17;
    localparam int GCOEF_W  = 17;
    localparam int PLASMA_W = 20;

    // configuration port
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ASPECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 1'b1;

endpackage

// ----- hw/rtl/fpc_rnd.sv -----
// rounds an unsigned product on its magnitude, clips it and restores the sign
module fpc_rnd
    import fpc_pkg::*;
#(
    parameter int PW = 50,
    parameter int SH = 16,
    parameter int OW = 40
) (
    input  logic [PW-1:0]        i_prod,
    input  logic                 i_neg,
    output logic signed [OW-1:0] o_val,
    output logic                 o_over
);

    localparam int RW = PW + 1 - SH;
    localparam int CW = (RW > OW) ? RW : OW;

    logic [PW:0]   q;
    logic [CW-1:0] r;
    logic [OW-2:0] mag;
    logic [OW-1:0] pos;

    // round half away from zero on the magnitude
    assign q = {1'b0, i_prod} + ((PW + 1)'(1) << (SH - 1));
    assign r = CW'(q[PW:SH]);

    // clip to the positive accumulator limit
    assign o_over = |r[CW-1:OW-1];
    assign mag    = o_over ? {(OW - 1){1'b1}} : r[OW-2:0];
    assign pos    = {1'b0, mag};

    // apply the sign
    assign o_val = i_neg ? (~pos + 1'b1) : pos;

endmodule

// ----- hw/rtl/fpc_sat.sv -----
// clips a signed value to a narrower signed range and flags the clip
module fpc_sat
    import fpc_pkg::*;
#(
    parameter int IW = 41,
    parameter int OW = 32
) (
    input  logic signed [IW-1:0] i_val,
    output logic signed [OW-1:0] o_val,
    output logic                 o_clip
);

    localparam logic signed [IW-1:0] MAXV = {{(IW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
    localparam logic signed [IW-1:0] MINV = ~MAXV;

    // compare against both limits
    always_comb begin
        priority if (i_val > MAXV) begin
            o_val  = MAXV[OW-1:0];
            o_clip = 1'b1;
        end else if (i_val < MINV) begin
            o_val  = MINV[OW-1:0];
            o_clip = 1'b1;
        end else begin
            o_val  = i_val[OW-1:0];
            o_clip = 1'b0;
        end
    end

endmodule

// ----- hw/rtl/fdtd_plasma_efield_cell_update.sv -----
// top level: pipelined d, e and polarization update of one fdtd grid cell
//
//  channel   direction  handshake            payload
//  item      in         i_start / o_busy     i_d_old .. i_metal
//  result    out        o_done (strobe)      o_d_new o_e_new o_pol_new o_saturated
//  config    in         i_cfg_we             i_cfg_idx i_cfg_data
//
// one item per clock while o_busy is low; a result comes out once the beat has passed
// the input register and eleven pipeline stages set by the three product chains
// o_busy is high only in reset and the first cycle after it
// synchronous active-low reset clears the valid bits of all stages; items in flight are dropped
// results are strobed for one cycle and cannot be held off
module fdtd_plasma_efield_cell_update
    import fpc_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int FIELD_BITS = FIELD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [FIELD_BITS-1:0] i_d_old,
    input  logic signed [FIELD_BITS-1:0] i_hy_here,
    input  logic signed [FIELD_BITS-1:0] i_hy_left,
    input  logic signed [FIELD_BITS-1:0] i_hx_here,
    input  logic signed [FIELD_BITS-1:0] i_hx_below,
    input  logic signed [FIELD_BITS-1:0] i_pol_last,
    input  logic signed [FIELD_BITS-1:0] i_pol_before,
    input  logic [GCOEF_W-1:0]           i_pml_g2,
    input  logic [GCOEF_W-1:0]           i_pml_g3,
    input  logic [PLASMA_W-1:0]          i_plasma_coeff,
    input  logic signed [FIELD_BITS-1:0] i_source_add,
    input  logic                         i_metal,
    output logic                         o_done,
    output logic signed [FIELD_BITS-1:0] o_d_new,
    output logic signed [FIELD_BITS-1:0] o_e_new,
    output logic signed [FIELD_BITS-1:0] o_pol_new,
    output logic                         o_saturated
);

    localparam int F     = FIELD_BITS;
    localparam int W1    = FIELD_BITS + 1;
    localparam int ACC   = FIELD_BITS + ACC_GUARD;
    localparam int TXP_W = W1 + ASPECT_W;
    localparam int G3P_W = F + GCOEF_W;
    localparam int DCP_W = W1 + DECAY_W;
    localparam int CUP_W = ACC + GCOEF_W;
    localparam int PLP_W = F + PLASMA_W;
    localparam int NSTG  = 11;

    localparam logic [ASPECT_W-1:0] ASPECT_RST = ASPECT_W'(1 << FRAC_BITS);
    localparam logic [DECAY_W-1:0]  DECAY_RST  = DECAY_W'(1 << FRAC_BITS);

    // control
    logic              r_live;
    logic [NSTG-1:0]   r_vld;
    logic              r_done;
    logic              accept;

    // configuration registers
    logic [ASPECT_W-1:0] r_aspect;
    logic [DECAY_W-1:0]  r_decay;

    // stage 0: captured item
    logic signed [F-1:0] r0_d_old, r0_hy_here, r0_hy_left, r0_hx_here, r0_hx_below;
    logic signed [F-1:0] r0_pol_last, r0_pol_before, r0_src;
    logic [GCOEF_W-1:0]  r0_g2, r0_g3;
    logic [PLASMA_W-1:0] r0_plasma;
    logic                r0_metal;

    // stage 1: differences and magnitudes
    logic signed [W1-1:0] n_dhx, n_dhy, n_dp;
    logic [W1-1:0]        r1_dhx_mag, r1_dp_mag;
    logic                 r1_dhx_neg, r1_dp_neg;
    logic signed [W1-1:0] r1_dhy;
    logic [F-1:0]         r1_dold_mag;
    logic                 r1_dold_neg;
    logic [GCOEF_W-1:0]   r1_g2, r1_g3;
    logic [PLASMA_W-1:0]  r1_plasma;
    logic signed [F-1:0]  r1_src, r1_pol_last;
    logic                 r1_metal;

    // stage 2: first products
    logic [TXP_W-1:0]     r2_tx_prod;
    logic [G3P_W-1:0]     r2_g3_prod;
    logic [DCP_W-1:0]     r2_dc_prod;
    logic                 r2_tx_neg, r2_g3_neg, r2_dc_neg;
    logic signed [W1-1:0] r2_dhy;
    logic [GCOEF_W-1:0]   r2_g2;
    logic [PLASMA_W-1:0]  r2_plasma;
    logic signed [F-1:0]  r2_src, r2_pol_last;
    logic                 r2_metal;

    // stage 3: rounded first products
    logic signed [ACC-1:0] n_tx, n_g3t, n_dct;
    logic                  n_tx_ov, n_g3_ov, n_dc_ov;
    logic signed [ACC-1:0] r3_tx, r3_g3t, r3_dct;
    logic                  r3_dflag, r3_dc_ov;
    logic signed [W1-1:0]  r3_dhy;
    logic [GCOEF_W-1:0]    r3_g2;
    logic [PLASMA_W-1:0]   r3_plasma;
    logic signed [F-1:0]   r3_src, r3_pol_last;
    logic                  r3_metal;

    // stage 4: curl
    logic signed [ACC:0]   n_curl_sum;
    logic signed [ACC-1:0] n_curl;
    logic                  n_curl_clip;
    logic signed [ACC-1:0] r4_curl, r4_g3t, r4_dct;
    logic                  r4_dflag, r4_dc_ov;
    logic [GCOEF_W-1:0]    r4_g2;
    logic [PLASMA_W-1:0]   r4_plasma;
    logic signed [F-1:0]   r4_src, r4_pol_last;
    logic                  r4_metal;

    // stage 5: curl product
    logic [ACC-1:0]        n_curl_mag;
    logic [CUP_W-1:0]      r5_cu_prod;
    logic                  r5_cu_neg;
    logic signed [ACC-1:0] r5_g3t, r5_dct;
    logic                  r5_dflag, r5_dc_ov;
    logic [PLASMA_W-1:0]   r5_plasma;
    logic signed [F-1:0]   r5_src, r5_pol_last;
    logic                  r5_metal;

    // stage 6: rounded half curl term
    logic signed [ACC-1:0] n_cut;
    logic                  n_cu_ov;
    logic signed [ACC-1:0] r6_cut, r6_g3t, r6_dct;
    logic                  r6_dflag, r6_dc_ov;
    logic [PLASMA_W-1:0]   r6_plasma;
    logic signed [F-1:0]   r6_src, r6_pol_last;
    logic                  r6_metal;

    // stage 7: new d
    logic signed [ACC+1:0] n_d_sum;
    logic signed [F-1:0]   n_d_clip;
    logic                  n_d_ov;
    logic signed [F-1:0]   r7_d;
    logic                  r7_sat, r7_dc_ov;
    logic signed [ACC-1:0] r7_dct;
    logic [PLASMA_W-1:0]   r7_plasma;
    logic signed [F-1:0]   r7_pol_last;

    // stage 8: e field
    logic signed [F:0]     n_e_dif;
    logic signed [F-1:0]   n_e;
    logic                  n_e_ov;
    logic signed [F-1:0]   r8_d, r8_e, r8_pol_last;
    logic [F-1:0]          r8_e_mag;
    logic                  r8_e_neg, r8_sat;
    logic signed [ACC-1:0] r8_dct;
    logic [PLASMA_W-1:0]   r8_plasma;

    // stage 9: plasma product
    logic [PLP_W-1:0]      r9_pl_prod;
    logic                  r9_pl_neg, r9_sat;
    logic signed [F-1:0]   r9_d, r9_e, r9_pol_last;
    logic signed [ACC-1:0] r9_dct;

    // stage 10: rounded plasma term
    logic signed [ACC-1:0] n_plt;
    logic                  n_pl_ov;
    logic signed [ACC-1:0] r10_plt, r10_dct;
    logic                  r10_sat;
    logic signed [F-1:0]   r10_d, r10_e, r10_pol_last;

    // output stage: new polarization
    logic signed [ACC+1:0] n_s_sum;
    logic signed [F-1:0]   n_s;
    logic                  n_s_ov;
    logic signed [F-1:0]   r_d_new, r_e_new, r_pol_new;
    logic                  r_sat;

    assign accept = i_start & r_live;
    assign o_busy = ~r_live;

    // control: live flag, valid bits and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_live <= 1'b1;
            r_vld  <= {r_vld[NSTG-2:0], accept};
            r_done <= r_vld[NSTG-1];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aspect <= ASPECT_RST;
            r_decay  <= DECAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ASPECT: r_aspect <= i_cfg_data[ASPECT_W-1:0];
                REG_DECAY:  r_decay  <= i_cfg_data[DECAY_W-1:0];
            endcase
        end
    end

    // stage 1 differences
    assign n_dhx = W1'(r0_hx_here) - W1'(r0_hx_below);
    assign n_dhy = W1'(r0_hy_here) - W1'(r0_hy_left);
    assign n_dp  = W1'(r0_pol_last) - W1'(r0_pol_before);

    // stage 3 rounding of the first products
    fpc_rnd #(.PW(TXP_W), .SH(FRAC_BITS), .OW(ACC)) u_rnd_tx (
        .i_prod (r2_tx_prod),
        .i_neg  (r2_tx_neg),
        .o_val  (n_tx),
        .o_over (n_tx_ov)
    );

    fpc_rnd #(.PW(G3P_W), .SH(FRAC_BITS), .OW(ACC)) u_rnd_g3 (
        .i_prod (r2_g3_prod),
        .i_neg  (r2_g3_neg),
        .o_val  (n_g3t),
        .o_over (n_g3_ov)
    );

    fpc_rnd #(.PW(DCP_W), .SH(FRAC_BITS), .OW(ACC)) u_rnd_dc (
        .i_prod (r2_dc_prod),
        .i_neg  (r2_dc_neg),
        .o_val  (n_dct),
        .o_over (n_dc_ov)
    );

    // stage 4 curl with clip to the accumulator
    assign n_curl_sum = (ACC + 1)'(r3_dhy) - (ACC + 1)'(r3_tx);

    fpc_sat #(.IW(ACC + 1), .OW(ACC)) u_sat_curl (
        .i_val  (n_curl_sum),
        .o_val  (n_curl),
        .o_clip (n_curl_clip)
    );

    // stage 5 curl magnitude
    assign n_curl_mag = r4_curl[ACC-1] ? ACC'(-r4_curl) : ACC'(r4_curl);

    // stage 6 half factor folded into the shift
    fpc_rnd #(.PW(CUP_W), .SH(FRAC_BITS + 1), .OW(ACC)) u_rnd_cu (
        .i_prod (r5_cu_prod),
        .i_neg  (r5_cu_neg),
        .o_val  (n_cut),
        .o_over (n_cu_ov)
    );

    // stage 7 d sum and clip
    assign n_d_sum = (ACC + 2)'(r6_g3t) + (ACC + 2)'(r6_cut) + (ACC + 2)'(r6_src);

    fpc_sat #(.IW(ACC + 2), .OW(F)) u_sat_d (
        .i_val  (n_d_sum),
        .o_val  (n_d_clip),
        .o_clip (n_d_ov)
    );

    // stage 8 e difference and clip
    assign n_e_dif = (F + 1)'(r7_d) - (F + 1)'(r7_pol_last);

    fpc_sat #(.IW(F + 1), .OW(F)) u_sat_e (
        .i_val  (n_e_dif),
        .o_val  (n_e),
        .o_clip (n_e_ov)
    );

    // stage 10 rounding of the plasma product
    fpc_rnd #(.PW(PLP_W), .SH(FRAC_BITS), .OW(ACC)) u_rnd_pl (
        .i_prod (r9_pl_prod),
        .i_neg  (r9_pl_neg),
        .o_val  (n_plt),
        .o_over (n_pl_ov)
    );

    // output polarization sum and clip
    assign n_s_sum = (ACC + 2)'(r10_pol_last) + (ACC + 2)'(r10_dct) + (ACC + 2)'(r10_plt);

    fpc_sat #(.IW(ACC + 2), .OW(F)) u_sat_s (
        .i_val  (n_s_sum),
        .o_val  (n_s),
        .o_clip (n_s_ov)
    );

    // datapath registers; only the result beat is qualified by the valid bits
    always_ff @(posedge i_clk) begin
        // stage 0
        r0_d_old      <= i_d_old;
        r0_hy_here    <= i_hy_here;
        r0_hy_left    <= i_hy_left;
        r0_hx_here    <= i_hx_here;
        r0_hx_below   <= i_hx_below;
        r0_pol_last   <= i_pol_last;
        r0_pol_before <= i_pol_before;
        r0_g2         <= i_pml_g2;
        r0_g3         <= i_pml_g3;
        r0_plasma     <= i_plasma_coeff;
        r0_src        <= i_source_add;
        r0_metal      <= i_metal;

        // stage 1
        r1_dhx_mag  <= n_dhx[W1-1] ? W1'(-n_dhx) : W1'(n_dhx);
        r1_dhx_neg  <= n_dhx[W1-1];
        r1_dp_mag   <= n_dp[W1-1] ? W1'(-n_dp) : W1'(n_dp);
        r1_dp_neg   <= n_dp[W1-1];
        r1_dold_mag <= r0_d_old[F-1] ? F'(-r0_d_old) : F'(r0_d_old);
        r1_dold_neg <= r0_d_old[F-1];
        r1_dhy      <= n_dhy;
        r1_g2       <= r0_g2;
        r1_g3       <= r0_g3;
        r1_plasma   <= r0_plasma;
        r1_src      <= r0_src;
        r1_pol_last <= r0_pol_last;
        r1_metal    <= r0_metal;

        // stage 2
        r2_tx_prod  <= r1_dhx_mag * r_aspect;
        r2_tx_neg   <= r1_dhx_neg;
        r2_g3_prod  <= r1_dold_mag * r1_g3;
        r2_g3_neg   <= r1_dold_neg;
        r2_dc_prod  <= r1_dp_mag * r_decay;
        r2_dc_neg   <= r1_dp_neg;
        r2_dhy      <= r1_dhy;
        r2_g2       <= r1_g2;
        r2_plasma   <= r1_plasma;
        r2_src      <= r1_src;
        r2_pol_last <= r1_pol_last;
        r2_metal    <= r1_metal;

        // stage 3
        r3_tx       <= n_tx;
        r3_g3t      <= n_g3t;
        r3_dct      <= n_dct;
        r3_dflag    <= n_tx_ov | n_g3_ov;
        r3_dc_ov    <= n_dc_ov;
        r3_dhy      <= r2_dhy;
        r3_g2       <= r2_g2;
        r3_plasma   <= r2_plasma;
        r3_src      <= r2_src;
        r3_pol_last <= r2_pol_last;
        r3_metal    <= r2_metal;

        // stage 4
        r4_curl     <= n_curl;
        r4_dflag    <= r3_dflag | n_curl_clip;
        r4_g3t      <= r3_g3t;
        r4_dct      <= r3_dct;
        r4_dc_ov    <= r3_dc_ov;
        r4_g2       <= r3_g2;
        r4_plasma   <= r3_plasma;
        r4_src      <= r3_src;
        r4_pol_last <= r3_pol_last;
        r4_metal    <= r3_metal;

        // stage 5
        r5_cu_prod  <= n_curl_mag * r4_g2;
        r5_cu_neg   <= r4_curl[ACC-1];
        r5_dflag    <= r4_dflag;
        r5_g3t      <= r4_g3t;
        r5_dct      <= r4_dct;
        r5_dc_ov    <= r4_dc_ov;
        r5_plasma   <= r4_plasma;
        r5_src      <= r4_src;
        r5_pol_last <= r4_pol_last;
        r5_metal    <= r4_metal;

        // stage 6
        r6_cut      <= n_cut;
        r6_dflag    <= r5_dflag | n_cu_ov;
        r6_g3t      <= r5_g3t;
        r6_dct      <= r5_dct;
        r6_dc_ov    <= r5_dc_ov;
        r6_plasma   <= r5_plasma;
        r6_src      <= r5_src;
        r6_pol_last <= r5_pol_last;
        r6_metal    <= r5_metal;

        // stage 7: metal cell forces d to zero and hides its clip
        r7_d        <= r6_metal ? '0 : n_d_clip;
        r7_sat      <= ~r6_metal & (r6_dflag | n_d_ov);
        r7_dct      <= r6_dct;
        r7_dc_ov    <= r6_dc_ov;
        r7_plasma   <= r6_plasma;
        r7_pol_last <= r6_pol_last;

        // stage 8
        r8_d        <= r7_d;
        r8_e        <= n_e;
        r8_e_mag    <= n_e[F-1] ? F'(-n_e) : F'(n_e);
        r8_e_neg    <= n_e[F-1];
        r8_sat      <= r7_sat | r7_dc_ov | n_e_ov;
        r8_dct      <= r7_dct;
        r8_plasma   <= r7_plasma;
        r8_pol_last <= r7_pol_last;

        // stage 9
        r9_pl_prod  <= r8_e_mag * r8_plasma;
        r9_pl_neg   <= r8_e_neg;
        r9_sat      <= r8_sat;
        r9_d        <= r8_d;
        r9_e        <= r8_e;
        r9_dct      <= r8_dct;
        r9_pol_last <= r8_pol_last;

        // stage 10
        r10_plt      <= n_plt;
        r10_sat      <= r9_sat | n_pl_ov;
        r10_d        <= r9_d;
        r10_e        <= r9_e;
        r10_dct      <= r9_dct;
        r10_pol_last <= r9_pol_last;

        // result beat
        if (r_vld[NSTG-1]) begin
            r_d_new   <= r10_d;
            r_e_new   <= r10_e;
            r_pol_new <= n_s;
            r_sat     <= r10_sat | n_s_ov;
        end
    end

    assign o_done      = r_done;
    assign o_d_new     = r_d_new;
    assign o_e_new     = r_e_new;
    assign o_pol_new   = r_pol_new;
    assign o_saturated = r_sat;

endmodule

// ----- hw/rtl/fpc_chk.sv -----
// port-level checks on the cell update handshake and latency
module fpc_chk
    import fpc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done
);

    localparam int LAT = 12;

    // reset kills any result beat
    a_rst_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result beat right after reset");

    // block takes items in every cycle whose previous cycle was out of reset
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !o_busy)
        else $error("busy outside reset");

    // every result beat traces back to an item taken earlier by the latency of the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result beat without matching item");

endmodule

bind fdtd_plasma_efield_cell_update fpc_chk u_fpc_chk (.*);
